### rtl/core/dsu_pkg.sv
// Shared types and constants for the disjoint-set union engine.
// Used by the top level and the testbench; no dependencies.
`timescale 1ns / 1ps

package dsu_pkg;

  localparam int IDX_W  = 10;
  localparam int CNT_W  = 11;
  localparam int RANK_W = 4;
  localparam int MODE_W = 2;

  localparam logic [RANK_W-1:0] RANK_MAX  = 4'd15;
  localparam logic [CNT_W-1:0]  COUNT_MAX = 11'd2047;

  // operation codes; the unused code behaves as a find
  localparam logic [MODE_W-1:0] MODE_INIT  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FIND  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_UNION = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0] root;
    logic [CNT_W-1:0] set_size;
    logic             merged;
  } out_item_t;

  // per-element bookkeeping kept apart from the parent links
  typedef struct packed {
    logic              is_root;
    logic [RANK_W-1:0] tree_rank;
    logic [CNT_W-1:0]  member_count;
  } meta_t;

  localparam int META_W = $bits(meta_t);

  localparam meta_t META_SINGLETON = '{is_root: 1'b1, tree_rank: '0, member_count: 11'd1};

endpackage

### rtl/core/disjoint_set_union_engine_top.sv
// Disjoint-set union engine top level: sequencer, index wrap unit, output register.
// Depends on dsu_pkg and dsu_ram (parent link table and metadata table).
`timescale 1ns / 1ps

// Usage:
//   Raise start with an item on in_item while busy is low; the item is taken at
//   that edge and busy rises for the whole operation. Each item yields exactly
//   one result, shown on out_item for a single cycle with out_valid high; the
//   receiver cannot stall, so it must capture the result in that cycle.
//   Init (mode 0) makes index_a..index_b singletons, then finds index_a.
//   Find (modes 1, 3) returns root and set size of index_a with path compression.
//   Union (mode 2) finds both roots and links them by rank.
//   Sequence: a find starts at its index, walks the parent links to the root, then
//   points each node it passed straight at the root; a union runs two finds
//   and, when the roots differ, the two merge states; an init first clears
//   index_a..index_b one element at a time. When NUM_ELEMENTS is below 1024
//   each index first passes the shared reciprocal-multiply wrap unit. The
//   registered read of both tables, on one shared read address, sets the walk pace.
//   Reset: busy stays high while a clearing pass writes every metadata entry
//   back to a singleton; the parent table is not cleared.
//   A new item may be taken in the cycle its predecessor's result is shown.

module disjoint_set_union_engine_top #(
  parameter int NUM_ELEMENTS = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  dsu_pkg::in_item_t  in_item,
  output logic               out_valid,
  output dsu_pkg::out_item_t out_item
);

  import dsu_pkg::*;

  localparam int IW = $clog2(NUM_ELEMENTS);
  localparam bit NEED_WRAP = (NUM_ELEMENTS < (1 << IDX_W));
  // reciprocal of NUM_ELEMENTS, exact for every index of IDX_W bits
  localparam int RSH = IDX_W + IW;
  localparam int RCP_W = IDX_W + 2;
  localparam int RCP_FULL = ((1 << RSH) + NUM_ELEMENTS - 1) / NUM_ELEMENTS;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_FULL);
  localparam logic [IDX_W-1:0] WRAP_N = IDX_W'(NUM_ELEMENTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_ELEMENTS - 1);

  // sequencer states
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_WRAP = 4'd2;
  localparam logic [3:0] S_INIT = 4'd3;
  localparam logic [3:0] S_FRD  = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_CMP  = 4'd6;
  localparam logic [3:0] S_CMPW = 4'd7;
  localparam logic [3:0] S_MRG1 = 4'd8;
  localparam logic [3:0] S_MRG2 = 4'd9;

  logic [3:0]        state_r, state_nxt;
  logic [IW-1:0]     clr_r, clr_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [IW-1:0]     a_r, a_nxt;
  logic [IW-1:0]     b_r, b_nxt;
  logic [IW-1:0]     i_r, i_nxt;
  logic [IW-1:0]     cur_r, cur_nxt;
  logic [IW-1:0]     x_r, x_nxt;
  logic [IW-1:0]     root_r, root_nxt;
  logic [RANK_W-1:0] rk_r, rk_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]     ra_r, ra_nxt;
  logic [RANK_W-1:0] rka_r, rka_nxt;
  logic [CNT_W-1:0]  cnta_r, cnta_nxt;
  logic              fsel_r, fsel_nxt;
  logic [IDX_W-1:0]  wv_r, wv_nxt;
  logic [IDX_W-1:0]  braw_r, braw_nxt;
  logic [IDX_W-1:0]  wq_r, wq_nxt;
  logic [1:0]        wph_r, wph_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_item_r, out_item_nxt;

  // table ports
  logic          par_we, meta_we;
  logic [IW-1:0] par_waddr, meta_waddr, raddr;
  logic [IW-1:0] par_wdata, par_q;
  meta_t         meta_wdata, meta_q;

  // shared unit: reciprocal multiply, then multiply back and subtract
  logic [IDX_W+RCP_W-1:0] wprod;
  logic [IDX_W-1:0]       wquo;
  logic [2*IDX_W-1:0]     wback;
  logic [IDX_W-1:0]       wrem;
  // merge arithmetic
  logic             a_wins;
  logic [CNT_W:0]   sum_wide;
  logic [CNT_W-1:0] sum_sat;
  logic [RANK_W-1:0] new_rank;
  // sequencer events
  logic             dispatch, find_done, start_find;
  logic [IW-1:0]    disp_a, disp_b, find_x;

  dsu_ram #(.WIDTH(IW), .DEPTH(NUM_ELEMENTS)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (raddr),
    .rdata (par_q)
  );

  dsu_ram #(.WIDTH(META_W), .DEPTH(NUM_ELEMENTS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (raddr),
    .rdata (meta_q)
  );

  assign wprod = {{RCP_W{1'b0}}, wv_r} * {{IDX_W{1'b0}}, RCP};
  assign wquo  = IDX_W'(wprod >> RSH);
  assign wback = {{IDX_W{1'b0}}, wq_r} * {{IDX_W{1'b0}}, WRAP_N};
  assign wrem  = wv_r - wback[IDX_W-1:0];

  assign a_wins   = (rka_r > rk_r);
  assign sum_wide = {1'b0, cnta_r} + {1'b0, cnt_r};
  assign sum_sat  = sum_wide[CNT_W] ? COUNT_MAX : sum_wide[CNT_W-1:0];

  // bump rank on a tie, index_b's root staying root
  always_comb begin
    if (a_wins) begin
      new_rank = rka_r;
    end else if ((rka_r == rk_r) && (rk_r < RANK_MAX)) begin
      new_rank = rk_r + 1'b1;
    end else begin
      new_rank = rk_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    mode_nxt      = mode_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    i_nxt         = i_r;
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    root_nxt      = root_r;
    rk_nxt        = rk_r;
    cnt_nxt       = cnt_r;
    ra_nxt        = ra_r;
    rka_nxt       = rka_r;
    cnta_nxt      = cnta_r;
    fsel_nxt      = fsel_r;
    wv_nxt        = wv_r;
    braw_nxt      = braw_r;
    wq_nxt        = wq_r;
    wph_nxt       = wph_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    par_we        = 1'b0;
    par_waddr     = x_r;
    par_wdata     = root_r;
    meta_we       = 1'b0;
    meta_waddr    = clr_r;
    meta_wdata    = META_SINGLETON;
    raddr         = cur_r;
    dispatch      = 1'b0;
    disp_a        = a_r;
    disp_b        = b_r;
    find_done     = 1'b0;
    start_find    = 1'b0;
    find_x        = a_r;

    unique case (state_r)
      S_CLR: begin
        meta_we = 1'b1;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          mode_nxt = in_item.mode;
          if (NEED_WRAP) begin
            wv_nxt    = in_item.index_a;
            braw_nxt  = in_item.index_b;
            wph_nxt   = '0;
            state_nxt = S_WRAP;
          end else begin
            dispatch = 1'b1;
            disp_a   = IW'(in_item.index_a);
            disp_b   = IW'(in_item.index_b);
          end
        end
      end
      S_WRAP: begin
        // quotient first, then remainder; index_a before index_b
        if (!wph_r[0]) begin
          wq_nxt  = wquo;
          wph_nxt = wph_r + 1'b1;
        end else if (!wph_r[1]) begin
          a_nxt   = IW'(wrem);
          wv_nxt  = braw_r;
          wph_nxt = wph_r + 1'b1;
        end else begin
          dispatch = 1'b1;
          disp_a   = a_r;
          disp_b   = IW'(wrem);
        end
      end
      S_INIT: begin
        meta_we    = 1'b1;
        meta_waddr = i_r;
        i_nxt      = i_r + 1'b1;
        if (i_r == b_r) begin
          start_find = 1'b1;
          find_x     = a_r;
        end
      end
      S_FRD: begin
        raddr     = cur_r;
        state_nxt = S_WALK;
      end
      S_WALK: begin
        // follow links until the root mark shows up
        if (meta_q.is_root) begin
          root_nxt  = cur_r;
          rk_nxt    = meta_q.tree_rank;
          cnt_nxt   = meta_q.member_count;
          state_nxt = S_CMP;
        end else begin
          cur_nxt = par_q;
          raddr   = par_q;
        end
      end
      S_CMP: begin
        if (x_r == root_r) begin
          find_done = 1'b1;
        end else begin
          raddr     = x_r;
          state_nxt = S_CMPW;
        end
      end
      S_CMPW: begin
        // point this node at the root and step to its old parent
        par_we    = 1'b1;
        par_waddr = x_r;
        par_wdata = root_r;
        x_nxt     = par_q;
        raddr     = par_q;
        if (par_q == root_r) begin
          find_done = 1'b1;
        end
      end
      S_MRG1: begin
        // hang the losing root under the winner
        par_we     = 1'b1;
        par_waddr  = a_wins ? root_r : ra_r;
        par_wdata  = a_wins ? ra_r : root_r;
        meta_we    = 1'b1;
        meta_waddr = par_waddr;
        meta_wdata = a_wins ? meta_t'{is_root: 1'b0, tree_rank: rk_r, member_count: cnt_r}
                            : meta_t'{is_root: 1'b0, tree_rank: rka_r, member_count: cnta_r};
        state_nxt  = S_MRG2;
      end
      S_MRG2: begin
        meta_we       = 1'b1;
        meta_waddr    = a_wins ? ra_r : root_r;
        meta_wdata    = '{is_root: 1'b1, tree_rank: new_rank, member_count: sum_sat};
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{root: IDX_W'(meta_waddr), set_size: sum_sat, merged: 1'b1};
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // route an accepted item to its first phase
    if (dispatch) begin
      a_nxt    = disp_a;
      b_nxt    = disp_b;
      fsel_nxt = 1'b0;
      if ((mode_nxt == MODE_INIT) && (disp_a <= disp_b)) begin
        i_nxt     = disp_a;
        state_nxt = S_INIT;
      end else begin
        start_find = 1'b1;
        find_x     = disp_a;
      end
    end

    // finish a find: report, start the second find, or merge
    if (find_done) begin
      if ((mode_r == MODE_UNION) && !fsel_r) begin
        ra_nxt     = root_r;
        rka_nxt    = rk_r;
        cnta_nxt   = cnt_r;
        fsel_nxt   = 1'b1;
        start_find = 1'b1;
        find_x     = b_r;
      end else if ((mode_r == MODE_UNION) && (ra_r != root_r)) begin
        state_nxt = S_MRG1;
      end else begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{root: IDX_W'(root_r), set_size: cnt_r, merged: 1'b0};
        state_nxt     = S_IDLE;
      end
    end

    if (start_find) begin
      cur_nxt   = find_x;
      x_nxt     = find_x;
      state_nxt = S_FRD;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    i_r        <= i_nxt;
    cur_r      <= cur_nxt;
    x_r        <= x_nxt;
    root_r     <= root_nxt;
    rk_r       <= rk_nxt;
    cnt_r      <= cnt_nxt;
    ra_r       <= ra_nxt;
    rka_r      <= rka_nxt;
    cnta_r     <= cnta_nxt;
    fsel_r     <= fsel_nxt;
    wv_r       <= wv_nxt;
    braw_r     <= braw_nxt;
    wq_r       <= wq_nxt;
    wph_r      <= wph_nxt;
    out_item_r <= out_item_nxt;
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // a result strobe lasts one cycle
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // no result while the clearing pass runs
  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLR) |-> !out_valid)
    else $error("result shown during clearing pass");

  // a real merge always joins at least two members
  a_merge_size: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.merged) |-> (out_item.set_size >= 11'd2))
    else $error("merged set smaller than two");

endmodule

### rtl/core/dsu_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; no package dependencies.
`timescale 1ns / 1ps

module dsu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, old data on a same-address collision
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for disjoint_set_union_engine_top: init, find and union items
// checked against a union-find predictor with rank, member counts and path compression.
// Depends on dsu_pkg and the engine RTL only.
`timescale 1ns / 1ps

module testbench;
  import dsu_pkg::*;

  localparam int TBL_DEPTH = 1 << IDX_W;
  localparam int TOP_INDEX = TBL_DEPTH - 1;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 400;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int DRAIN_CYCLES = 64;

  // Union-find predictor plus queue of expected results, oldest first
  class dsu_scoreboard;
    logic [IDX_W-1:0]  link_tbl [TBL_DEPTH];
    bit                root_flag [TBL_DEPTH];
    logic [RANK_W-1:0] rank_tbl [TBL_DEPTH];
    logic [CNT_W-1:0]  count_tbl [TBL_DEPTH];
    out_item_t         expected_q [$];
    int unsigned       fail_count;

    function new();
      for (int i = 0; i < TBL_DEPTH; i++) begin
        make_singleton(i);
      end
      fail_count = 0;
    endfunction

    function void make_singleton(int unsigned i);
      link_tbl[i]  = '0;
      root_flag[i] = 1'b1;
      rank_tbl[i]  = '0;
      count_tbl[i] = CNT_W'(1);
    endfunction

    // walk up to the root without touching the table
    function int unsigned trace_root(int unsigned x);
      int unsigned r;
      int unsigned steps;
      r = x;
      steps = 0;
      while (!root_flag[r] && steps < TBL_DEPTH) begin
        r = 32'(link_tbl[r]);
        steps++;
      end
      return r;
    endfunction

    // find the root, then point every node on the walk straight at it
    function int unsigned find_compress(int unsigned x);
      int unsigned r;
      int unsigned nxt;
      int unsigned steps;
      r = trace_root(x);
      steps = 0;
      while (x != r && !root_flag[x] && steps < TBL_DEPTH) begin
        nxt = 32'(link_tbl[x]);
        link_tbl[x] = r[IDX_W-1:0];
        x = nxt;
        steps++;
      end
      return r;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // apply one accepted item and queue the result it must produce
    function void note_input(in_item_t it);
      int unsigned a;
      int unsigned b;
      int unsigned ra;
      int unsigned rb;
      int unsigned root;
      int unsigned sum;
      out_item_t exp_item;
      a = 32'(it.index_a);
      b = 32'(it.index_b);
      exp_item.merged = 1'b0;
      case (it.mode)
        MODE_INIT: begin
          for (int unsigned i = a; i <= b; i++) begin
            make_singleton(i);
          end
          root = find_compress(a);
        end
        MODE_UNION: begin
          ra = find_compress(a);
          rb = find_compress(b);
          root = ra;
          if (ra != rb) begin
            sum = 32'(count_tbl[ra]) + 32'(count_tbl[rb]);
            if (sum > 32'(COUNT_MAX)) sum = 32'(COUNT_MAX);
            if (rank_tbl[ra] > rank_tbl[rb]) begin
              link_tbl[rb]  = ra[IDX_W-1:0];
              root_flag[rb] = 1'b0;
              count_tbl[ra] = sum[CNT_W-1:0];
              root = ra;
            end else begin
              link_tbl[ra]  = rb[IDX_W-1:0];
              root_flag[ra] = 1'b0;
              count_tbl[rb] = sum[CNT_W-1:0];
              if (rank_tbl[ra] == rank_tbl[rb] && rank_tbl[rb] < RANK_MAX)
                rank_tbl[rb] = rank_tbl[rb] + 1'b1;
              root = rb;
            end
            exp_item.merged = 1'b1;
          end
        end
        default: begin
          root = find_compress(a);
        end
      endcase
      exp_item.root = root[IDX_W-1:0];
      exp_item.set_size = count_tbl[root];
      expected_q = {expected_q, exp_item};
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      fail_count++;
    endtask

    // compare one result field by field against the oldest expectation
    task check_result(out_item_t got);
      out_item_t exp_item;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: root %0d size %0d merged %0d",
                                  got.root, got.set_size, got.merged));
      end else begin
        exp_item = expected_q.pop_front();
        if (got.root !== exp_item.root)
          report_mismatch($sformatf("root %0d, want %0d", got.root, exp_item.root));
        if (got.set_size !== exp_item.set_size)
          report_mismatch($sformatf("set_size %0d, want %0d", got.set_size,
                                    exp_item.set_size));
        if (got.merged !== exp_item.merged)
          report_mismatch($sformatf("merged %0d, want %0d", got.merged, exp_item.merged));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    in_item = '0;
  logic        out_valid;
  out_item_t   out_item;

  dsu_scoreboard sb;
  bit            steady = 1'b0;
  int unsigned   cycle_count = 0;

  disjoint_set_union_engine_top #(
    .NUM_ELEMENTS(TBL_DEPTH)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always #1 clk = ~clk;

  // Check results first, then note a newly accepted item
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) sb.check_result(out_item);
      if (start && !busy) sb.note_input(in_item);
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Offer one item after a random gap and hold it until accepted
  task automatic send_item(input logic [MODE_W-1:0] op, input int unsigned a,
                           input int unsigned b);
    int unsigned gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= '{mode: op, index_a: a[IDX_W-1:0], index_b: b[IDX_W-1:0]};
    do @(posedge clk); while (busy);
  endtask

  // Drop start and wait until every expected result has come back
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Join every element into the set of first, each new one with a random earlier one
  task automatic merge_all(input int unsigned first);
    int unsigned order [TBL_DEPTH];
    int unsigned j;
    int unsigned tmp;
    int unsigned anchor;
    j = 1;
    order[0] = first;
    for (int unsigned i = 0; i < TBL_DEPTH; i++) begin
      if (i != first) begin
        order[j] = i;
        j++;
      end
    end
    for (int unsigned k = TBL_DEPTH - 1; k > 1; k--) begin
      j = $urandom_range(1, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int unsigned k = 1; k < TBL_DEPTH; k++) begin
      anchor = order[$urandom_range(0, k - 1)];
      if ($urandom_range(0, 1) != 0) send_item(MODE_UNION, order[k], anchor);
      else send_item(MODE_UNION, anchor, order[k]);
    end
  endtask

  // Extremes, tie and rank rules, same-set union, empty and partial inits
  task automatic run_directed();
    send_item(MODE_FIND, 0, TOP_INDEX);
    send_item(MODE_FIND, TOP_INDEX, 0);
    send_item(MODE_UNION, 0, 1);
    send_item(MODE_UNION, 1, 0);
    send_item(MODE_UNION, 2, 1);
    send_item(MODE_UNION, TOP_INDEX, TOP_INDEX - 1);
    send_item(MODE_UNION, TOP_INDEX - 1, 1);
    send_item(MODE_FIND, TOP_INDEX, 0);
    send_item(MODE_SPARE, TOP_INDEX, TOP_INDEX);
    send_item(MODE_UNION, TOP_INDEX, 2);
    send_item(MODE_INIT, 5, 3);
    send_item(MODE_INIT, 2, 2);
    send_item(MODE_UNION, 2, TOP_INDEX);
    send_item(MODE_INIT, 1, 1);
    send_item(MODE_FIND, 0, 0);
    send_item(MODE_UNION, 10'h2AA, 10'h155);
    send_item(MODE_UNION, 10'h155, 10'h2AA);
    send_item(MODE_INIT, 0, TOP_INDEX);
    send_item(MODE_UNION, 512, 512);
    send_item(MODE_FIND, 512, 0);
  endtask

  // Build one full set, reset all but its root, then join fresh singletons onto its count
  task automatic run_full_set();
    int unsigned hub;
    int unsigned loner;
    send_item(MODE_INIT, 0, TOP_INDEX);
    merge_all($urandom_range(0, TOP_INDEX));
    wait_idle();
    hub = sb.trace_root(0);
    if (hub > 0) send_item(MODE_INIT, 0, hub - 1);
    if (hub < TOP_INDEX) send_item(MODE_INIT, hub + 1, TOP_INDEX);
    repeat (3) begin
      loner = $urandom_range(0, TOP_INDEX);
      if (loner == hub) loner = (hub + 1) % TBL_DEPTH;
      send_item(MODE_INIT, loner, loner);
      send_item(MODE_UNION, loner, hub);
    end
  endtask

  // Bursts of unions and finds inside a small window, with partial inits and noise
  task automatic run_random();
    int unsigned sent;
    int unsigned base;
    int unsigned span;
    int unsigned burst;
    int unsigned pick;
    int unsigned a;
    int unsigned b;
    logic [MODE_W-1:0] op;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      span = 1 << $urandom_range(2, 7);
      base = $urandom_range(0, TBL_DEPTH - span);
      burst = $urandom_range(20, 120);
      steady = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1) != 0) begin
        send_item(MODE_INIT, base, base + span - 1);
        sent++;
      end
      repeat (burst) begin
        pick = $urandom_range(0, 99);
        a = base + $urandom_range(0, span - 1);
        b = base + $urandom_range(0, span - 1);
        if (pick < 55) begin
          send_item(MODE_UNION, a, b);
        end else if (pick < 70) begin
          send_item(MODE_FIND, a, b);
        end else if (pick < 75) begin
          send_item(MODE_SPARE, a, b);
        end else if (pick < 82) begin
          // short range inside the window, sometimes empty
          if ($urandom_range(0, 4) == 0 && a > 0) b = a - 1;
          else b = a + $urandom_range(0, 3);
          if (b > base + span - 1) b = base + span - 1;
          send_item(MODE_INIT, a, b);
        end else begin
          // anywhere in the table, any code
          a = $urandom_range(0, TOP_INDEX);
          b = $urandom_range(0, TOP_INDEX);
          op = MODE_W'($urandom_range(0, 3));
          if (op == MODE_INIT && b >= a && $urandom_range(0, 49) != 0) begin
            b = a + $urandom_range(0, 7);
            if (b > TOP_INDEX) b = TOP_INDEX;
          end
          send_item(op, a, b);
        end
        sent++;
      end
    end
    steady = 1'b0;
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_full_set();
    run_random();
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
